FILE: design/bpr_cp_factor_sgd_step_macros.svh
// Assertion macros for the factor SGD step block.
// Used by the top level only; no other dependencies.
`ifndef BPR_CP_FACTOR_SGD_STEP_MACROS_SVH
`define BPR_CP_FACTOR_SGD_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bpr_pkg.sv
// Shared types, constants and Q8.24 helper functions for the factor SGD step.
// No dependencies.
`default_nettype none

package bpr_pkg;

    localparam int FACTORS_DEF = 64;
    localparam int USERS_DEF   = 1024;
    localparam int TOPS_DEF    = 1024;
    localparam int BOTTOMS_DEF = 1024;
    localparam int SHOES_DEF   = 1024;

    localparam int          LR_W     = 25;
    localparam logic [24:0] LR_RESET = 25'd167772;

    localparam logic signed [31:0] ONE_Q = 32'sd16777216;

    typedef logic signed [31:0] t_q;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TRAIN = 2'd2;

    // table codes
    localparam logic [1:0] TBL_USER   = 2'd0;
    localparam logic [1:0] TBL_TOP    = 2'd1;
    localparam logic [1:0] TBL_BOTTOM = 2'd2;
    localparam logic [1:0] TBL_SHOE   = 2'd3;

    function automatic t_q sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return t_q'(x[31:0]);
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat32(s);
    endfunction

    // logistic(k/2), k = 0..16, Q8.24
    function automatic t_q logistic_tab(input logic [4:0] k);
        t_q v;
        unique case (k)
            5'd0:    v = 32'sd8388608;
            5'd1:    v = 32'sd10443135;
            5'd2:    v = 32'sd12265128;
            5'd3:    v = 32'sd13716624;
            5'd4:    v = 32'sd14777323;
            5'd5:    v = 32'sd15504527;
            5'd6:    v = 32'sd15981542;
            5'd7:    v = 32'sd16285438;
            5'd8:    v = 32'sd16475458;
            5'd9:    v = 32'sd16592886;
            5'd10:   v = 32'sd16664929;
            5'd11:   v = 32'sd16708930;
            5'd12:   v = 32'sd16735732;
            5'd13:   v = 32'sd16752030;
            5'd14:   v = 32'sd16761931;
            5'd15:   v = 32'sd16767942;
            default: v = 32'sd16771590;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/bpr_qmul.sv
// Shared Q8.24 multiplier: round-half-up and saturate, or floored >>23 for
// table interpolation. Depends on bpr_pkg.
`default_nettype none

module bpr_qmul (
    input  bpr_pkg::t_q i_a,
    input  bpr_pkg::t_q i_b,
    input  logic        i_lin,
    output bpr_pkg::t_q o_q
);
    import bpr_pkg::*;

    logic signed [63:0] prod;
    logic signed [63:0] scaled;

    assign prod = 64'(i_a) * 64'(i_b);

    always_comb begin
        if (i_lin) begin
            scaled = prod >>> 23;
        end else begin
            scaled = (prod + 64'sd8388608) >>> 24;
        end
    end

    assign o_q = sat32(scaled);

endmodule

`default_nettype wire

FILE: design/bpr_cp_factor_sgd_step.sv
// Factor SGD step top level: four factor tables, index reduction, sequencer.
// Depends on bpr_pkg, bpr_qmul and bpr_cp_factor_sgd_step_macros.svh.
//
// One item is taken at a time. o_in_stall is high from the accepting edge until
// the sequencer is back in idle, which it reaches at the edge that moves the result
// into the output register. One result may wait there while the next item is taken, but
// a second finished result waits in the sequencer while i_out_stall holds the
// first. Every item first reduces its indices modulo the table sizes
// (reciprocal multiply, then multiply back and subtract), then passes a dispatch
// state. A write then goes straight to the done state and a read passes the
// read-wait state first. A training item makes two passes over the FACTORS
// factors through the one shared multiplier: a scoring pass, a logistic step,
// an update pass, and then the done state that queues the result. The tables
// are single-port memories and are not cleared after reset.
`default_nettype none
`include "bpr_cp_factor_sgd_step_macros.svh"

module bpr_cp_factor_sgd_step #(
    parameter int FACTORS = bpr_pkg::FACTORS_DEF,
    parameter int USERS   = bpr_pkg::USERS_DEF,
    parameter int TOPS    = bpr_pkg::TOPS_DEF,
    parameter int BOTTOMS = bpr_pkg::BOTTOMS_DEF,
    parameter int SHOES   = bpr_pkg::SHOES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [24:0]        i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [1:0]         i_table_select,
    input  logic [9:0]         i_entry_index,
    input  logic [5:0]         i_factor_index,
    input  logic signed [31:0] i_load_value,
    input  logic [9:0]         i_user_index,
    input  logic [9:0]         i_top_pos,
    input  logic [9:0]         i_bottom_pos,
    input  logic [9:0]         i_shoe_pos,
    input  logic [9:0]         i_top_neg,
    input  logic [9:0]         i_bottom_neg,
    input  logic [9:0]         i_shoe_neg,
    // results
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_score_diff,
    output logic signed [31:0] o_read_value
);
    import bpr_pkg::*;

    localparam int FIW   = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int ACC_W = 34 + FIW;
    localparam int DU    = FACTORS * USERS;
    localparam int DT    = FACTORS * TOPS;
    localparam int DB    = FACTORS * BOTTOMS;
    localparam int DS    = FACTORS * SHOES;
    localparam int AW_U  = (DU > 1) ? $clog2(DU) : 1;
    localparam int AW_T  = (DT > 1) ? $clog2(DT) : 1;
    localparam int AW_B  = (DB > 1) ? $clog2(DB) : 1;
    localparam int AW_S  = (DS > 1) ? $clog2(DS) : 1;
    localparam int LANES = 9;

    // reciprocals ceil(2^RCP_SH / m): exact quotients for 10-bit indices
    localparam int RCP_SH = 27;
    localparam int RCP_F  = ((1 << RCP_SH) + FACTORS - 1) / FACTORS;
    localparam int RCP_U  = ((1 << RCP_SH) + USERS - 1) / USERS;
    localparam int RCP_T  = ((1 << RCP_SH) + TOPS - 1) / TOPS;
    localparam int RCP_B  = ((1 << RCP_SH) + BOTTOMS - 1) / BOTTOMS;
    localparam int RCP_S  = ((1 << RCP_SH) + SHOES - 1) / SHOES;

    // lane order of the index registers
    localparam int L_ENT = 0;
    localparam int L_FAC = 1;
    localparam int L_USR = 2;
    localparam int L_TP  = 3;
    localparam int L_BP  = 4;
    localparam int L_SP  = 5;
    localparam int L_TN  = 6;
    localparam int L_BN  = 7;
    localparam int L_SN  = 8;

    // update pass step numbers, then the last steps of the scoring and logistic passes
    localparam logic [5:0] S_LAT_POS  = 6'd1;
    localparam logic [5:0] S_LAT_NEG  = 6'd2;
    localparam logic [5:0] S_G        = 6'd8;
    localparam logic [5:0] S_UADD     = 6'd11;
    localparam logic [5:0] S_GRP0     = 6'd12;
    localparam logic [5:0] S_GRP_END  = 6'd35;
    localparam logic [5:0] S_WR_POS   = 6'd36;
    localparam logic [5:0] S_WR_NEG   = 6'd37;
    localparam logic [5:0] S_ACC      = 6'd8;
    localparam logic [5:0] S_SIG_LAST = 6'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MOD, ST_OP, ST_RDW, ST_SCORE, ST_SIG, ST_UPD, ST_DONE
    } t_state;

    t_state r_state;
    logic [5:0]  r_step;
    logic        r_cnt;
    logic [FIW-1:0] r_fac;
    logic [24:0] r_lr;
    logic        r_ov;

    logic [1:0]  r_kind;
    logic [1:0]  r_sel;
    t_q          r_load;
    logic [9:0]  r_ix [LANES];
    logic [9:0]  r_quo [LANES];

    t_q r_u, r_tp, r_tn, r_bp, r_bn, r_sp, r_sn;
    t_q r_t, r_t2, r_g, r_ut, r_bs, r_utn, r_bsn;
    t_q r_ys, r_sigma, r_nsig, r_lbase;
    logic r_big;
    logic signed [ACC_W-1:0] r_acc;
    t_q r_res_score, r_res_rd;
    t_q r_out_score, r_out_rd;

    // ---------------- index reduction moduli ----------------
    logic [16:0] lane_mod [LANES];
    logic [27:0] lane_rcp [LANES];

    always_comb begin
        unique case (r_sel)
            TBL_USER: begin
                lane_mod[L_ENT] = 17'(USERS);
                lane_rcp[L_ENT] = 28'(RCP_U);
            end
            TBL_TOP: begin
                lane_mod[L_ENT] = 17'(TOPS);
                lane_rcp[L_ENT] = 28'(RCP_T);
            end
            TBL_BOTTOM: begin
                lane_mod[L_ENT] = 17'(BOTTOMS);
                lane_rcp[L_ENT] = 28'(RCP_B);
            end
            default: begin
                lane_mod[L_ENT] = 17'(SHOES);
                lane_rcp[L_ENT] = 28'(RCP_S);
            end
        endcase
        lane_mod[L_FAC] = 17'(FACTORS);
        lane_mod[L_USR] = 17'(USERS);
        lane_mod[L_TP]  = 17'(TOPS);
        lane_mod[L_BP]  = 17'(BOTTOMS);
        lane_mod[L_SP]  = 17'(SHOES);
        lane_mod[L_TN]  = 17'(TOPS);
        lane_mod[L_BN]  = 17'(BOTTOMS);
        lane_mod[L_SN]  = 17'(SHOES);
        lane_rcp[L_FAC] = 28'(RCP_F);
        lane_rcp[L_USR] = 28'(RCP_U);
        lane_rcp[L_TP]  = 28'(RCP_T);
        lane_rcp[L_BP]  = 28'(RCP_B);
        lane_rcp[L_SP]  = 28'(RCP_S);
        lane_rcp[L_TN]  = 28'(RCP_T);
        lane_rcp[L_BN]  = 28'(RCP_B);
        lane_rcp[L_SN]  = 28'(RCP_S);
    end

    // ---------------- memories ----------------
    logic is_train;
    logic neg_sel;
    logic [FIW-1:0] fac_sel;
    logic [9:0] ent_u, ent_t, ent_b, ent_s;
    logic [AW_U-1:0] addr_u;
    logic [AW_T-1:0] addr_t;
    logic [AW_B-1:0] addr_b;
    logic [AW_S-1:0] addr_s;
    logic we_u, we_t, we_b, we_s;
    logic op_wr;
    t_q wd_u, wd_t, wd_b, wd_s;
    t_q q_u, q_t, q_b, q_s;

    assign is_train = (r_state == ST_SCORE) || (r_state == ST_UPD);
    assign neg_sel  = (r_step == S_LAT_POS) || (r_step == S_WR_NEG);
    assign fac_sel  = is_train ? r_fac : r_ix[L_FAC][FIW-1:0];
    assign ent_u    = is_train ? r_ix[L_USR] : r_ix[L_ENT];
    assign ent_t    = is_train ? (neg_sel ? r_ix[L_TN] : r_ix[L_TP]) : r_ix[L_ENT];
    assign ent_b    = is_train ? (neg_sel ? r_ix[L_BN] : r_ix[L_BP]) : r_ix[L_ENT];
    assign ent_s    = is_train ? (neg_sel ? r_ix[L_SN] : r_ix[L_SP]) : r_ix[L_ENT];

    assign addr_u = AW_U'(32'(fac_sel) * 32'(USERS) + 32'(ent_u));
    assign addr_t = AW_T'(32'(fac_sel) * 32'(TOPS) + 32'(ent_t));
    assign addr_b = AW_B'(32'(fac_sel) * 32'(BOTTOMS) + 32'(ent_b));
    assign addr_s = AW_S'(32'(fac_sel) * 32'(SHOES) + 32'(ent_s));

    assign op_wr = (r_state == ST_OP) && (r_kind == KIND_WRITE);
    assign we_u  = (op_wr && r_sel == TBL_USER) ||
                   (r_state == ST_UPD && r_step == S_WR_POS);
    assign we_t  = (op_wr && r_sel == TBL_TOP) ||
                   (r_state == ST_UPD && (r_step == S_WR_POS || r_step == S_WR_NEG));
    assign we_b  = (op_wr && r_sel == TBL_BOTTOM) ||
                   (r_state == ST_UPD && (r_step == S_WR_POS || r_step == S_WR_NEG));
    assign we_s  = (op_wr && r_sel == TBL_SHOE) ||
                   (r_state == ST_UPD && (r_step == S_WR_POS || r_step == S_WR_NEG));
    assign wd_u  = is_train ? r_u : r_load;
    assign wd_t  = is_train ? (neg_sel ? r_tn : r_tp) : r_load;
    assign wd_b  = is_train ? (neg_sel ? r_bn : r_bp) : r_load;
    assign wd_s  = is_train ? (neg_sel ? r_sn : r_sp) : r_load;

    t_q mem_u [DU];
    t_q mem_t [DT];
    t_q mem_b [DB];
    t_q mem_s [DS];

    always_ff @(posedge i_clk) begin
        if (we_u) begin
            mem_u[addr_u] <= wd_u;
        end
        q_u <= mem_u[addr_u];
    end

    always_ff @(posedge i_clk) begin
        if (we_t) begin
            mem_t[addr_t] <= wd_t;
        end
        q_t <= mem_t[addr_t];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[addr_b] <= wd_b;
        end
        q_b <= mem_b[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (we_s) begin
            mem_s[addr_s] <= wd_s;
        end
        q_s <= mem_s[addr_s];
    end

    // ---------------- shared multiplier operand select ----------------
    logic [5:0] grp_rel;
    logic [2:0] grp;
    logic       in_grp;
    t_q grp_coef, grp_other, grp_tgt, grp_new;
    t_q alpha;
    logic [32:0] mag;
    logic signed [32:0] ys_x;
    logic [3:0]  tidx;
    t_q lin_diff;
    t_q mul_a, mul_b, mq;
    logic mul_lin;
    t_q sig_l;

    assign alpha   = t_q'({7'b0, r_lr});
    assign grp_rel = r_step - S_GRP0;
    assign grp     = grp_rel[4:2];
    assign in_grp  = (r_step >= S_GRP0) && (r_step <= S_GRP_END);

    always_comb begin
        unique case (grp)
            3'd0:    begin grp_coef = r_bs;  grp_other = r_u;  grp_tgt = r_tp; end
            3'd1:    begin grp_coef = r_bsn; grp_other = r_u;  grp_tgt = r_tn; end
            3'd2:    begin grp_coef = r_ut;  grp_other = r_sp; grp_tgt = r_bp; end
            3'd3:    begin grp_coef = r_utn; grp_other = r_sn; grp_tgt = r_bn; end
            3'd4:    begin grp_coef = r_ut;  grp_other = r_bp; grp_tgt = r_sp; end
            default: begin grp_coef = r_utn; grp_other = r_bn; grp_tgt = r_sn; end
        endcase
    end

    assign grp_new = qadd(grp_tgt, r_t);

    assign ys_x     = 33'(r_ys);
    assign mag      = r_ys[31] ? 33'(-ys_x) : 33'(ys_x);
    assign tidx     = mag[26:23];
    assign lin_diff = logistic_tab(5'(tidx) + 5'd1) - logistic_tab(5'(tidx));
    assign sig_l    = r_big ? logistic_tab(5'd16) : r_lbase + r_t;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_lin = 1'b0;
        unique case (r_state)
            ST_SCORE: begin
                case (r_step)
                    6'd2:    begin mul_a = r_u;  mul_b = r_tp; end
                    6'd3:    begin mul_a = r_t;  mul_b = r_bp; end
                    6'd4:    begin mul_a = r_t;  mul_b = r_sp; end
                    6'd5:    begin mul_a = r_u;  mul_b = r_tn; end
                    6'd6:    begin mul_a = r_t2; mul_b = r_bn; end
                    6'd7:    begin mul_a = r_t2; mul_b = r_sn; end
                    default: ;
                endcase
            end
            ST_SIG: begin
                mul_a   = lin_diff;
                mul_b   = t_q'({9'b0, mag[22:0]});
                mul_lin = 1'b1;
            end
            ST_UPD: begin
                if (in_grp) begin
                    unique case (r_step[1:0])
                        2'd0: begin
                            mul_a = grp[0] ? r_nsig : r_sigma;
                            mul_b = grp_coef;
                        end
                        2'd1: begin mul_a = r_t;   mul_b = grp_other; end
                        2'd2: begin mul_a = alpha; mul_b = r_t;       end
                        default: ;
                    endcase
                end else begin
                    case (r_step)
                        6'd2:    begin mul_a = r_u;     mul_b = r_tp;  end
                        6'd3:    begin mul_a = r_bp;    mul_b = r_sp;  end
                        6'd4:    begin mul_a = r_u;     mul_b = r_tn;  end
                        6'd5:    begin mul_a = r_bn;    mul_b = r_sn;  end
                        6'd6:    begin mul_a = r_tp;    mul_b = r_bs;  end
                        6'd7:    begin mul_a = r_tn;    mul_b = r_bsn; end
                        6'd9:    begin mul_a = r_sigma; mul_b = r_g;   end
                        6'd10:   begin mul_a = alpha;   mul_b = r_t;   end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    bpr_qmul u_qmul (
        .i_a   (mul_a),
        .i_b   (mul_b),
        .i_lin (mul_lin),
        .o_q   (mq)
    );

    // ---------------- sequencer ----------------
    logic in_acc, out_free, last_fac;
    logic al_t, al_b, al_s;
    logic [36:0] lane_prod [LANES];
    logic [9:0]  lane_back [LANES];

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign last_fac = (r_fac == FIW'(FACTORS - 1));
    assign al_t     = (r_ix[L_TP] == r_ix[L_TN]);
    assign al_b     = (r_ix[L_BP] == r_ix[L_BN]);
    assign al_s     = (r_ix[L_SP] == r_ix[L_SN]);

    // remainder fits in 10 bits, so the low bits of quotient * modulus suffice
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_prod[i] = 37'(r_ix[i]) * 37'(lane_rcp[i]);
            lane_back[i] = 10'(27'(r_quo[i]) * 27'(lane_mod[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_cnt   <= 1'b0;
            r_fac   <= '0;
            r_lr    <= LR_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lr <= i_cfg_data;
            end
            if (r_ov && !i_out_stall && r_state != ST_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_kind        <= i_kind;
                        r_sel         <= i_table_select;
                        r_load        <= i_load_value;
                        r_ix[L_ENT]   <= i_entry_index;
                        r_ix[L_FAC]   <= {4'b0, i_factor_index};
                        r_ix[L_USR]   <= i_user_index;
                        r_ix[L_TP]    <= i_top_pos;
                        r_ix[L_BP]    <= i_bottom_pos;
                        r_ix[L_SP]    <= i_shoe_pos;
                        r_ix[L_TN]    <= i_top_neg;
                        r_ix[L_BN]    <= i_bottom_neg;
                        r_ix[L_SN]    <= i_shoe_neg;
                        r_cnt         <= 1'b1;
                        r_state       <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    // quotient first, then index minus quotient times modulus
                    if (r_cnt) begin
                        for (int i = 0; i < LANES; i++) begin
                            r_quo[i] <= lane_prod[i][36:27];
                        end
                        r_cnt <= 1'b0;
                    end else begin
                        for (int i = 0; i < LANES; i++) begin
                            r_ix[i] <= r_ix[i] - lane_back[i];
                        end
                        r_state <= ST_OP;
                    end
                end
                ST_OP: begin
                    r_res_score <= '0;
                    r_res_rd    <= '0;
                    r_step      <= '0;
                    r_fac       <= '0;
                    r_acc       <= '0;
                    priority if (r_kind == KIND_READ) begin
                        r_state <= ST_RDW;
                    end else if (r_kind == KIND_TRAIN) begin
                        r_state <= ST_SCORE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_RDW: begin
                    unique case (r_sel)
                        TBL_USER:   r_res_rd <= q_u;
                        TBL_TOP:    r_res_rd <= q_t;
                        TBL_BOTTOM: r_res_rd <= q_b;
                        default:    r_res_rd <= q_s;
                    endcase
                    r_state <= ST_DONE;
                end
                ST_SCORE: begin
                    r_step <= (r_step == S_ACC) ? '0 : r_step + 6'd1;
                    case (r_step)
                        S_LAT_POS: begin
                            r_u <= q_u; r_tp <= q_t; r_bp <= q_b; r_sp <= q_s;
                        end
                        S_LAT_NEG: begin
                            r_tn <= q_t; r_bn <= q_b; r_sn <= q_s;
                            r_t  <= mq;
                        end
                        6'd3, 6'd4: r_t  <= mq;
                        6'd5, 6'd6, 6'd7: r_t2 <= mq;
                        S_ACC: begin
                            r_acc  <= r_acc + ACC_W'(r_t) - ACC_W'(r_t2);
                            if (last_fac) begin
                                r_fac   <= '0;
                                r_state <= ST_SIG;
                            end else begin
                                r_fac <= r_fac + FIW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                ST_SIG: begin
                    r_step <= (r_step == S_SIG_LAST) ? '0 : r_step + 6'd1;
                    case (r_step)
                        6'd0: r_ys <= sat32(64'(r_acc));
                        6'd1: begin
                            r_t     <= mq;
                            r_lbase <= logistic_tab(5'(tidx));
                            r_big   <= (mag[32:23] >= 10'd16);
                        end
                        6'd2: r_sigma <= (r_ys > 0) ? ONE_Q - sig_l : sig_l;
                        default: begin
                            r_nsig  <= -r_sigma;
                            r_state <= ST_UPD;
                        end
                    endcase
                end
                ST_UPD: begin
                    r_step <= (r_step == S_WR_NEG) ? '0 : r_step + 6'd1;
                    if (in_grp) begin
                        if (r_step[1:0] == 2'd3) begin
                            // shared positive / negative entries see each update in turn
                            unique case (grp)
                                3'd0: begin r_tp <= grp_new; if (al_t) r_tn <= grp_new; end
                                3'd1: begin r_tn <= grp_new; if (al_t) r_tp <= grp_new; end
                                3'd2: begin r_bp <= grp_new; if (al_b) r_bn <= grp_new; end
                                3'd3: begin r_bn <= grp_new; if (al_b) r_bp <= grp_new; end
                                3'd4: begin r_sp <= grp_new; if (al_s) r_sn <= grp_new; end
                                default: begin
                                    r_sn <= grp_new;
                                    if (al_s) r_sp <= grp_new;
                                end
                            endcase
                        end else begin
                            r_t <= mq;
                        end
                    end else begin
                        case (r_step)
                            S_LAT_POS: begin
                                r_u <= q_u; r_tp <= q_t; r_bp <= q_b; r_sp <= q_s;
                            end
                            S_LAT_NEG: begin
                                r_tn <= q_t; r_bn <= q_b; r_sn <= q_s;
                                r_ut <= mq;
                            end
                            6'd3:    r_bs  <= mq;
                            6'd4:    r_utn <= mq;
                            6'd5:    r_bsn <= mq;
                            6'd6:    r_t   <= mq;
                            6'd7:    r_t2  <= mq;
                            S_G:     r_g   <= sat32(64'(r_t) - 64'(r_t2));
                            6'd9, 6'd10: r_t <= mq;
                            S_UADD:  r_u   <= qadd(r_u, r_t);
                            S_WR_NEG: begin
                                if (last_fac) begin
                                    r_res_score <= r_ys;
                                    r_state     <= ST_DONE;
                                end else begin
                                    r_fac <= r_fac + FIW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_score <= r_res_score;
                        r_out_rd    <= r_res_rd;
                        r_ov        <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_ov;
    assign o_score_diff = r_out_score;
    assign o_read_value = r_out_rd;

    // ---------------- assertions ----------------
    `BPR_ASSERT_NEXT(a_accept_to_mod, i_clk, i_rst_n, in_acc, r_state == ST_MOD, "accept did not start index reduction")
    `BPR_ASSERT_SAME(a_idx_reduced, i_clk, i_rst_n, r_state == ST_OP, (r_ix[L_FAC] < 10'(FACTORS)) && ({7'b0, r_ix[L_USR]} < 17'(USERS)), "index not reduced")
    `BPR_ASSERT_SAME(a_sigma_range, i_clk, i_rst_n, r_state == ST_UPD, (r_sigma > 0) && (r_sigma <= ONE_Q), "sigma out of range")
    `BPR_ASSERT_SAME(a_nontrain_zero, i_clk, i_rst_n, (r_state == ST_DONE) && (r_kind != KIND_TRAIN), r_res_score == 0, "non-train item with nonzero score")

endmodule

`default_nettype wire

FILE: tb/bpr_sgd_checker.sv
// Scoreboard for the factor SGD step: tracks learning rate and factor tables,
// predicts score_diff/read_value per item and checks results in order.
// Depends on bpr_pkg (types, constants, kind and table codes).
`default_nettype none

module bpr_sgd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [24:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [1:0]         i_table_select,
    input  logic [9:0]         i_entry_index,
    input  logic [5:0]         i_factor_index,
    input  logic signed [31:0] i_load_value,
    input  logic [9:0]         i_user_index,
    input  logic [9:0]         i_top_pos,
    input  logic [9:0]         i_bottom_pos,
    input  logic [9:0]         i_shoe_pos,
    input  logic [9:0]         i_top_neg,
    input  logic [9:0]         i_bottom_neg,
    input  logic [9:0]         i_shoe_neg,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_score_diff,
    input  logic signed [31:0] i_read_value,
    output int                 o_fail_count,
    output int                 o_pending
);
    import bpr_pkg::*;

    typedef struct {
        t_q score;
        t_q rdval;
    } t_expect;

    localparam longint SIGMOID_LUT [17] = '{
        8388608, 10443135, 12265128, 13716624, 14777323, 15504527,
        15981542, 16285438, 16475458, 16592886, 16664929, 16708930,
        16735732, 16752030, 16761931, 16767942, 16771590
    };

    t_q          factor_mem [int];
    t_expect     expected_q [$];
    logic [24:0] step_size;

    function automatic int cell_key(logic [1:0] tsel, logic [9:0] ent, logic [5:0] fac);
        return int'({tsel, fac, ent});
    endfunction

    function automatic t_q peek(int k);
        return factor_mem.exists(k) ? factor_mem[k] : 32'sd0;
    endfunction

    function automatic t_q clamp32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return t_q'(x);
    endfunction

    // round half up, floor shift
    function automatic t_q fx_mul(t_q a, t_q b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd8388608;
        return clamp32(p >>> 24);
    endfunction

    function automatic t_q fx_add(t_q a, t_q b);
        return clamp32(longint'(a) + longint'(b));
    endfunction

    function automatic t_q sigmoid_abs(longint a);
        longint idx, frac;
        idx  = a >>> 23;
        frac = a & 64'h7fffff;
        if (idx >= 16) return t_q'(SIGMOID_LUT[16]);
        return t_q'(SIGMOID_LUT[idx] +
            (((SIGMOID_LUT[idx + 1] - SIGMOID_LUT[idx]) * frac) >>> 23));
    endfunction

    function automatic t_q sgd_pair_step();
        longint ypos, yneg, mag;
        t_q ys, sigma, nsig, alpha, u, unew, ut, bs, utn, bsn, g;
        int ku, ktp, ktn, kbp, kbn, ksp, ksn;
        ypos = 0;
        yneg = 0;
        alpha = t_q'({7'd0, step_size});
        for (int f = 0; f < 64; f++) begin
            u = peek(cell_key(TBL_USER, i_user_index, 6'(f)));
            ypos += fx_mul(fx_mul(fx_mul(u, peek(cell_key(TBL_TOP, i_top_pos, 6'(f)))),
                    peek(cell_key(TBL_BOTTOM, i_bottom_pos, 6'(f)))),
                    peek(cell_key(TBL_SHOE, i_shoe_pos, 6'(f))));
            yneg += fx_mul(fx_mul(fx_mul(u, peek(cell_key(TBL_TOP, i_top_neg, 6'(f)))),
                    peek(cell_key(TBL_BOTTOM, i_bottom_neg, 6'(f)))),
                    peek(cell_key(TBL_SHOE, i_shoe_neg, 6'(f))));
        end
        ys = clamp32(ypos - yneg);
        mag = (ys < 0) ? -longint'(ys) : longint'(ys);
        sigma = sigmoid_abs(mag);
        if (ys > 0) sigma = ONE_Q - sigma;
        nsig = -sigma;
        for (int f = 0; f < 64; f++) begin
            ku  = cell_key(TBL_USER, i_user_index, 6'(f));
            ktp = cell_key(TBL_TOP, i_top_pos, 6'(f));
            ktn = cell_key(TBL_TOP, i_top_neg, 6'(f));
            kbp = cell_key(TBL_BOTTOM, i_bottom_pos, 6'(f));
            kbn = cell_key(TBL_BOTTOM, i_bottom_neg, 6'(f));
            ksp = cell_key(TBL_SHOE, i_shoe_pos, 6'(f));
            ksn = cell_key(TBL_SHOE, i_shoe_neg, 6'(f));
            ut  = fx_mul(peek(ku), peek(ktp));
            bs  = fx_mul(peek(kbp), peek(ksp));
            utn = fx_mul(peek(ku), peek(ktn));
            bsn = fx_mul(peek(kbn), peek(ksn));
            g = clamp32(longint'(fx_mul(peek(ktp), bs)) - longint'(fx_mul(peek(ktn), bsn)));
            unew = fx_add(peek(ku), fx_mul(alpha, fx_mul(sigma, g)));
            factor_mem[ku] = unew;
            // shared pos/neg entries see the first update before the second
            factor_mem[ktp] = fx_add(peek(ktp), fx_mul(alpha, fx_mul(fx_mul(sigma, bs), unew)));
            factor_mem[ktn] = fx_add(peek(ktn), fx_mul(alpha, fx_mul(fx_mul(nsig, bsn), unew)));
            factor_mem[kbp] = fx_add(peek(kbp),
                fx_mul(alpha, fx_mul(fx_mul(sigma, ut), peek(ksp))));
            factor_mem[kbn] = fx_add(peek(kbn),
                fx_mul(alpha, fx_mul(fx_mul(nsig, utn), peek(ksn))));
            factor_mem[ksp] = fx_add(peek(ksp),
                fx_mul(alpha, fx_mul(fx_mul(sigma, ut), peek(kbp))));
            factor_mem[ksn] = fx_add(peek(ksn),
                fx_mul(alpha, fx_mul(fx_mul(nsig, utn), peek(kbn))));
        end
        return ys;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_expect e, got;
        if (!i_rst_n) begin
            step_size    = LR_RESET;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) step_size = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (i_score_diff !== e.score) begin
                        $error("score_diff: expected %0d, got %0d", e.score, i_score_diff);
                        o_fail_count++;
                    end
                    if (i_read_value !== e.rdval) begin
                        $error("read_value: expected %0d, got %0d", e.rdval, i_read_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                got.score = 0;
                got.rdval = 0;
                case (i_kind)
                    KIND_WRITE: factor_mem[cell_key(i_table_select, i_entry_index,
                        i_factor_index)] = i_load_value;
                    KIND_READ: got.rdval = peek(cell_key(i_table_select, i_entry_index,
                        i_factor_index));
                    KIND_TRAIN: got.score = sgd_pair_step();
                    default: ;
                endcase
                expected_q = {expected_q, got};
            end
        end
    end
endmodule

`default_nettype wire

FILE: tb/tb_bpr_cp_factor_sgd_step.sv
// Testbench top for bpr_cp_factor_sgd_step: reset, config phases, directed and
// random item traffic with bursty sender and stalling receiver.
// Depends on bpr_pkg, the DUT and bpr_sgd_checker.
`default_nettype none

module tb_bpr_cp_factor_sgd_step;
    import bpr_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  tsel;
        logic [9:0]  ent;
        logic [5:0]  fac;
        logic [31:0] val;
        logic [9:0]  usr, tp, bp, sp, tn, bn, sn;
    } t_item;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam logic [9:0] ENT_POOL [2] = '{10'd0, 10'd1023};
    localparam int CYCLE_LIMIT = 6000000;

    logic               clk = 0, rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [24:0]        cfg_data = '0;
    logic               in_valid = 0, in_stall;
    logic [1:0]         kind = '0, tsel = '0;
    logic [9:0]         ent = '0;
    logic [5:0]         fac = '0;
    logic signed [31:0] load_val = '0;
    logic [9:0]         usr = '0, tp = '0, bp = '0, sp = '0, tn = '0, bn = '0, sn = '0;
    logic               out_valid, out_stall = 0;
    logic signed [31:0] score_diff, read_value;
    int                 fail_count, pending;
    int                 n_sent = 0, n_recv = 0, cycles = 0;
    int                 burst_left = 0;

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    bpr_cp_factor_sgd_step u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_table_select(tsel), .i_entry_index(ent),
        .i_factor_index(fac), .i_load_value(load_val),
        .i_user_index(usr), .i_top_pos(tp), .i_bottom_pos(bp), .i_shoe_pos(sp),
        .i_top_neg(tn), .i_bottom_neg(bn), .i_shoe_neg(sn),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_score_diff(score_diff), .o_read_value(read_value)
    );

    bpr_sgd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_table_select(tsel), .i_entry_index(ent),
        .i_factor_index(fac), .i_load_value(load_val),
        .i_user_index(usr), .i_top_pos(tp), .i_bottom_pos(bp), .i_shoe_pos(sp),
        .i_top_neg(tn), .i_bottom_neg(bn), .i_shoe_neg(sn),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_score_diff(score_diff), .i_read_value(read_value),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (out_valid && !out_stall) n_recv++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall pattern: free-running, random and long-hold modes
    always @(negedge clk) begin
        int mode;
        mode = (cycles / 97) % 3;
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(99) < 35);
        else out_stall <= ((cycles % 23) < 15);
    end

    function automatic t_item blank_item();
        t_item it;
        it = '{default: '0};
        return it;
    endfunction

    function automatic logic [31:0] unit_value();
        return 32'($signed($urandom_range(33554432)) - 16777216);
    endfunction

    function automatic logic [9:0] pool_ent();
        return ENT_POOL[$urandom_range(1)];
    endfunction

    function automatic t_item write_item(logic [1:0] t, logic [9:0] e, logic [5:0] f,
                                         logic [31:0] v);
        t_item it;
        it = blank_item();
        it.kind = KIND_WRITE;
        it.tsel = t;
        it.ent = e;
        it.fac = f;
        it.val = v;
        return it;
    endfunction

    function automatic t_item read_item(logic [1:0] t, logic [9:0] e, logic [5:0] f);
        t_item it;
        it = write_item(t, e, f, $urandom());
        it.kind = KIND_READ;
        return it;
    endfunction

    function automatic t_item pair_item(bit shared);
        t_item it;
        it = blank_item();
        it.kind = KIND_TRAIN;
        it.usr = pool_ent();
        it.tp = pool_ent();
        it.bp = pool_ent();
        it.sp = pool_ent();
        it.tn = shared ? it.tp : pool_ent();
        it.bn = shared ? it.bp : pool_ent();
        it.sn = shared ? it.sp : pool_ent();
        it.tsel = 2'($urandom());
        it.ent = 10'($urandom());
        it.fac = 6'($urandom());
        it.val = $urandom();
        return it;
    endfunction

    task automatic send(t_item it);
        @(negedge clk);
        kind <= it.kind;
        tsel <= it.tsel;
        ent <= it.ent;
        fac <= it.fac;
        load_val <= it.val;
        usr <= it.usr;
        tp <= it.tp;
        bp <= it.bp;
        sp <= it.sp;
        tn <= it.tn;
        bn <= it.bn;
        sn <= it.sn;
        in_valid <= 1'b1;
        n_sent++;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_rate(logic [24:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_item it;
        logic [24:0] rates [5];
        int r;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every factor of the pooled entities gets a value before any read or train
        for (int t = 0; t < 4; t++)
            for (int e = 0; e < 2; e++)
                for (int f = 0; f < 64; f++)
                    send(write_item(2'(t), ENT_POOL[e], 6'(f), unit_value()));

        send(read_item(TBL_USER, 10'd0, 6'd0));
        send(read_item(TBL_SHOE, 10'd1023, 6'd63));
        send(write_item(TBL_TOP, 10'd1023, 6'd63, 32'h7fffffff));
        send(read_item(TBL_TOP, 10'd1023, 6'd63));
        it = pair_item(0);
        it.tp = 10'd1023;
        send(it);
        send(write_item(TBL_BOTTOM, 10'd0, 6'd0, 32'h80000000));
        send(read_item(TBL_BOTTOM, 10'd0, 6'd0));
        it = pair_item(0);
        it.bn = 10'd0;
        send(it);
        send(pair_item(1));
        it = pair_item(0);
        it.tn = it.tp;
        send(it);
        it = pair_item(0);
        it.kind = KIND_NOP;
        send(it);
        send(write_item(TBL_TOP, 10'd1023, 6'd63, unit_value()));
        send(write_item(TBL_BOTTOM, 10'd0, 6'd0, unit_value()));
        send(read_item(TBL_USER, 10'd1023, 6'd31));

        rates = '{25'd0, 25'd16777216, 25'h1ffffff, 25'($urandom_range(16777216)), LR_RESET};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_rate(rates[ph - 1]);
            end
            for (int n = 0; n < 37; n++) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    send(write_item(2'($urandom()), ($urandom_range(2) == 0) ? 10'($urandom())
                        : pool_ent(), 6'($urandom()), unit_value()));
                end else if (r < 55) begin
                    send(read_item(2'($urandom()), pool_ent(), 6'($urandom())));
                end else if (r < 80) begin
                    send(pair_item($urandom_range(6) == 0));
                end else if (r < 88) begin
                    it = pair_item(0);
                    it.kind = KIND_NOP;
                    send(it);
                end else begin
                    // full-range values into the pool to drive saturation
                    send(write_item(2'($urandom()), pool_ent(), 6'($urandom()), $urandom()));
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/bpr_pkg.sv
design/bpr_qmul.sv
design/bpr_cp_factor_sgd_step.sv
tb/bpr_sgd_checker.sv
tb/tb_bpr_cp_factor_sgd_step.sv
